FILE: rtl/core/sva_pkg.sv
package sva_pkg;

  localparam logic [1:0] REQ_NOTE_ON    = 2'd0;
  localparam logic [1:0] REQ_NOTE_OFF   = 2'd1;
  localparam logic [1:0] REQ_VOICE_DONE = 2'd2;
  localparam logic [1:0] REQ_ALL_OFF    = 2'd3;

  localparam logic [1:0] MODE_MONO   = 2'd1;
  localparam logic [1:0] MODE_LEGATO = 2'd2;

  localparam logic [0:0] CFG_VOICE_MODE = 1'd0;
  localparam logic [0:0] CFG_SAMPLE_MAP = 1'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY,
    ST_EMIT
  } sva_state_t;

  typedef struct packed {
    logic capture;
    logic scan;
    logic apply;
    logic load_out;
  } sva_cmd_t;

  typedef struct packed {
    logic need_scan;
    logic scan_last;
  } sva_stat_t;

endpackage

FILE: rtl/core/sva_ctrl.sv
module sva_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  sva_pkg::sva_stat_t stat,
  output sva_pkg::sva_cmd_t  cmd
);
  import sva_pkg::*;

  sva_state_t state;
  sva_state_t state_next;
  logic       out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = stat.need_scan ? ST_SCAN : ST_APPLY;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_last) begin
          state_next = ST_APPLY;
        end
      end
      ST_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  a_capture_moves_on: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> (state == ST_SCAN || state == ST_APPLY))
    else $error("capture did not start scan or apply");

  a_apply_then_emit: assert property (@(posedge clk) disable iff (rst)
    state == ST_APPLY |=> state == ST_EMIT)
    else $error("apply not followed by emit");

  a_scan_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && stat.scan_last) |=> state == ST_APPLY)
    else $error("scan overran its last voice");

  a_result_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_EMIT)
    else $error("result raised outside emit");

endmodule

FILE: rtl/core/sva_datapath.sv
module sva_datapath #(
  parameter int VOICES = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [1:0]         cfg_data,
  input  logic [1:0]         req_type,
  input  logic [6:0]         key_number,
  input  logic [2:0]         done_voice,
  input  sva_pkg::sva_cmd_t  cmd,
  output sva_pkg::sva_stat_t stat,
  output logic               accepted,
  output logic [2:0]         voice_index,
  output logic               retrigger,
  output logic               was_busy,
  output logic [7:0]         released_mask,
  output logic [7:0]         busy_mask,
  output logic [7:0]         gate_mask
);
  import sva_pkg::*;

  localparam int IDXW = $clog2(VOICES);

  logic [1:0]        voice_mode;
  logic              sample_map_present;

  logic [VOICES-1:0] voice_used;
  logic [VOICES-1:0] voice_gate;
  logic [6:0]        voice_note [VOICES];
  logic [31:0]       voice_age [VOICES];
  logic [31:0]       age_stamp;

  logic [1:0]        req_q;
  logic [6:0]        key_q;
  logic [2:0]        done_q;

  logic [IDXW-1:0]   idx;
  logic              found_rel;
  logic [IDXW-1:0]   best_rel;
  logic [31:0]       best_rel_age;
  logic [IDXW-1:0]   best_all;
  logic [31:0]       best_all_age;
  logic [VOICES-1:0] released;

  logic              res_acc;
  logic [IDXW-1:0]   res_sel;
  logic              res_rt;
  logic              res_busy;

  logic [IDXW-1:0]   free_idx;
  logic              any_free;
  logic              mono;
  logic [IDXW-1:0]   sel;
  logic [6:0]        scan_note;
  logic [31:0]       scan_age;
  logic [31:0]       sel_w;
  logic [31:0]       used_w;
  logic [31:0]       gate_w;
  logic [31:0]       rel_w;

  always_comb begin
    free_idx = '0;
    for (int v = VOICES - 1; v >= 0; v--) begin
      if (!voice_used[v]) begin
        free_idx = IDXW'(v);
      end
    end
  end

  assign any_free  = ~&voice_used;
  assign mono      = (voice_mode == MODE_MONO) || (voice_mode == MODE_LEGATO);
  assign scan_note = voice_note[idx];
  assign scan_age  = voice_age[idx];

  always_comb begin
    if (mono) begin
      sel = '0;
    end else if (any_free) begin
      sel = free_idx;
    end else if (found_rel) begin
      sel = best_rel;
    end else begin
      sel = best_all;
    end
  end

  assign stat.need_scan = (req_type == REQ_NOTE_OFF) ||
                          (req_type == REQ_NOTE_ON && sample_map_present && !mono && !any_free);
  assign stat.scan_last = (idx == IDXW'(VOICES - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      voice_mode         <= '0;
      sample_map_present <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_VOICE_MODE: voice_mode <= cfg_data;
        CFG_SAMPLE_MAP: sample_map_present <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // voice state flags and age counter
  always_ff @(posedge clk) begin
    if (rst) begin
      voice_used <= '0;
      voice_gate <= '0;
      age_stamp  <= '0;
    end else begin
      if (cmd.scan && req_q == REQ_NOTE_OFF) begin
        if (voice_used[idx] && voice_gate[idx] && scan_note == key_q) begin
          voice_gate[idx] <= 1'b0;
        end
      end
      if (cmd.apply) begin
        case (req_q)
          REQ_NOTE_ON: begin
            if (sample_map_present) begin
              voice_used[sel] <= 1'b1;
              voice_gate[sel] <= 1'b1;
              age_stamp       <= age_stamp + 32'd1;
            end
          end
          REQ_VOICE_DONE: begin
            for (int v = 0; v < VOICES; v++) begin
              if (32'(done_q) == 32'(v)) begin
                voice_used[v] <= 1'b0;
              end
            end
          end
          REQ_ALL_OFF: begin
            voice_used <= '0;
            voice_gate <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply && req_q == REQ_NOTE_ON && sample_map_present) begin
      voice_note[sel] <= key_q;
      voice_age[sel]  <= age_stamp;
    end
  end

  // request capture and scan
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q     <= req_type;
      key_q     <= key_number;
      done_q    <= done_voice;
      idx       <= '0;
      found_rel <= 1'b0;
      released  <= '0;
    end else if (cmd.scan) begin
      idx <= idx + IDXW'(1);
      if (req_q == REQ_NOTE_OFF) begin
        if (voice_used[idx] && voice_gate[idx] && scan_note == key_q) begin
          released[idx] <= 1'b1;
        end
      end else begin
        if (!voice_gate[idx] && (!found_rel || scan_age < best_rel_age)) begin
          found_rel    <= 1'b1;
          best_rel     <= idx;
          best_rel_age <= scan_age;
        end
        if (idx == '0 || scan_age < best_all_age) begin
          best_all     <= idx;
          best_all_age <= scan_age;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      if (req_q == REQ_NOTE_ON && sample_map_present) begin
        res_acc  <= 1'b1;
        res_sel  <= sel;
        res_rt   <= !(voice_mode == MODE_LEGATO && voice_used[sel] && voice_gate[sel]);
        res_busy <= voice_used[sel];
      end else begin
        res_acc  <= 1'b0;
        res_sel  <= '0;
        res_rt   <= 1'b0;
        res_busy <= 1'b0;
      end
    end
  end

  assign sel_w  = 32'(res_sel);
  assign used_w = 32'(voice_used);
  assign gate_w = 32'(voice_gate);
  assign rel_w  = 32'(released);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      accepted      <= res_acc;
      voice_index   <= sel_w[2:0];
      retrigger     <= res_rt;
      was_busy      <= res_busy;
      released_mask <= rel_w[7:0];
      busy_mask     <= used_w[7:0];
      gate_mask     <= gate_w[7:0];
    end
  end

endmodule

FILE: rtl/core/synth_voice_allocator.sv
// voice allocator for note events
// input channel: in_valid/in_ready with req_type, key_number, done_voice
// output channel: out_valid/out_ready, one result request per input request
// config: cfg_we writes cfg_data into register cfg_index (0 voice mode,
// 1 sample map present); the user must write only while no request is in
// flight, which the block itself does not enforce
// note off, and poly note on with the sample map present and every voice in
// use, first scan the note and age store, one voice per cycle: a note off
// releases each held voice with its key, a note on searches for the oldest
// released or oldest overall voice; all other requests skip the scan
// one request is processed at a time; the next is accepted once the previous
// result has been loaded into the output register
// a stalled receiver holds the result in the output register; a following
// request is still accepted and processed, then waits to be loaded
// reset clears all voices, the age counter and the config registers
module synth_voice_allocator #(
  parameter int VOICES = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [1:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] req_type,
  input  logic [6:0] key_number,
  input  logic [2:0] done_voice,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       accepted,
  output logic [2:0] voice_index,
  output logic       retrigger,
  output logic       was_busy,
  output logic [7:0] released_mask,
  output logic [7:0] busy_mask,
  output logic [7:0] gate_mask
);
  import sva_pkg::*;

  sva_cmd_t  cmd;
  sva_stat_t stat;

  sva_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sva_datapath #(
    .VOICES (VOICES)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .req_type      (req_type),
    .key_number    (key_number),
    .done_voice    (done_voice),
    .cmd           (cmd),
    .stat          (stat),
    .accepted      (accepted),
    .voice_index   (voice_index),
    .retrigger     (retrigger),
    .was_busy      (was_busy),
    .released_mask (released_mask),
    .busy_mask     (busy_mask),
    .gate_mask     (gate_mask)
  );

endmodule

FILE: bench/voice_alloc_checker.sv
`timescale 1ns / 100ps
module voice_alloc_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [1:0] cfg_data,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [1:0] req_type,
  input  logic [6:0] key_number,
  input  logic [2:0] done_voice,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic       accepted,
  input  logic [2:0] voice_index,
  input  logic       retrigger,
  input  logic       was_busy,
  input  logic [7:0] released_mask,
  input  logic [7:0] busy_mask,
  input  logic [7:0] gate_mask,
  output int         fail_count,
  output int         pending,
  output int         checked,
  output int         reused
);
  import sva_pkg::*;

  localparam int NUM_VOICES = 8;

  typedef struct packed {
    logic       accepted;
    logic [2:0] voice_index;
    logic       retrigger;
    logic       was_busy;
    logic [7:0] released_mask;
    logic [7:0] busy_mask;
    logic [7:0] gate_mask;
  } alloc_result_t;

  logic [1:0]  mode_reg;
  logic        map_reg;
  logic [7:0]  used;
  logic [7:0]  gate;
  logic [6:0]  note [NUM_VOICES];
  logic [31:0] age [NUM_VOICES];
  logic [31:0] stamp;

  alloc_result_t alloc_q[$];

  int errors = 0;
  int outstanding = 0;
  int compared = 0;
  int busy_hits = 0;

  assign fail_count = errors;
  assign pending    = outstanding;
  assign checked    = compared;
  assign reused     = busy_hits;

  // lowest free voice, else oldest released, else oldest overall
  function automatic logic [2:0] oldest_voice();
    int  best;
    bit  found;
    best  = 0;
    found = 1'b0;
    for (int v = 0; v < NUM_VOICES; v++) begin
      if (!used[v]) return 3'(v);
    end
    for (int v = 0; v < NUM_VOICES; v++) begin
      if (!gate[v] && (!found || age[v] < age[best])) begin
        best  = v;
        found = 1'b1;
      end
    end
    if (found) return 3'(best);
    for (int v = 1; v < NUM_VOICES; v++) begin
      if (age[v] < age[best]) best = v;
    end
    return 3'(best);
  endfunction

  function automatic alloc_result_t allocate_voice(logic [1:0] kind, logic [6:0] key,
                                                   logic [2:0] dv);
    alloc_result_t r;
    logic [2:0]    sel;
    logic          held;
    r = '0;
    case (kind)
      REQ_NOTE_ON: begin
        if (map_reg) begin
          sel = (mode_reg == MODE_MONO || mode_reg == MODE_LEGATO) ? 3'd0 : oldest_voice();
          held = used[sel] && gate[sel];
          r.was_busy  = used[sel];
          r.retrigger = !(mode_reg == MODE_LEGATO && held);
          used[sel] = 1'b1;
          gate[sel] = 1'b1;
          note[sel] = key;
          age[sel]  = stamp;
          stamp     = stamp + 32'd1;
          r.accepted    = 1'b1;
          r.voice_index = sel;
        end
      end
      REQ_NOTE_OFF: begin
        for (int v = 0; v < NUM_VOICES; v++) begin
          if (used[v] && gate[v] && note[v] == key) begin
            gate[v] = 1'b0;
            r.released_mask[v] = 1'b1;
          end
        end
      end
      REQ_VOICE_DONE: begin
        used[dv] = 1'b0;
      end
      default: begin
        used = '0;
        gate = '0;
      end
    endcase
    r.busy_mask = used;
    r.gate_mask = gate;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : watch
    alloc_result_t want;
    if (rst) begin
      mode_reg = '0;
      map_reg  = 1'b0;
      used     = '0;
      gate     = '0;
      stamp    = '0;
      for (int v = 0; v < NUM_VOICES; v++) begin
        note[v] = '0;
        age[v]  = '0;
      end
      alloc_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (alloc_q.size() == 0) begin
          $error("result with no request pending");
          errors++;
        end else begin
          want = alloc_q.pop_front();
          check_field("accepted", 8'(want.accepted), 8'(accepted));
          check_field("voice_index", 8'(want.voice_index), 8'(voice_index));
          check_field("retrigger", 8'(want.retrigger), 8'(retrigger));
          check_field("was_busy", 8'(want.was_busy), 8'(was_busy));
          check_field("released_mask", want.released_mask, released_mask);
          check_field("busy_mask", want.busy_mask, busy_mask);
          check_field("gate_mask", want.gate_mask, gate_mask);
          compared++;
          if (want.accepted && want.was_busy) busy_hits++;
        end
      end
      if (cfg_we) begin
        if (cfg_index == CFG_VOICE_MODE) mode_reg = cfg_data;
        else if (cfg_index == CFG_SAMPLE_MAP) map_reg = cfg_data[0];
      end
      if (in_valid && in_ready) begin
        alloc_q.push_back(allocate_voice(req_type, key_number, done_voice));
      end
    end
    outstanding = alloc_q.size();
  end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
  import sva_pkg::*;

  localparam logic [1:0] MODE_POLY  = 2'd0;
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int PHASES      = 9;
  localparam int PHASE_ITEMS = 92;
  localparam int LATENCY     = 11;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [1:0] PHASE_MODE [PHASES] = '{MODE_POLY, MODE_MONO, MODE_LEGATO,
                                                 MODE_SPARE, MODE_POLY, MODE_LEGATO,
                                                 MODE_MONO, MODE_SPARE, MODE_POLY};
  localparam logic PHASE_MAP [PHASES] = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1};

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [0:0] cfg_index = '0;
  logic [1:0] cfg_data = '0;
  logic       in_valid = 1'b0;
  logic [1:0] req_type = REQ_NOTE_ON;
  logic [6:0] key_number = '0;
  logic [2:0] done_voice = '0;
  logic       out_ready = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic       accepted;
  logic [2:0] voice_index;
  logic       retrigger;
  logic       was_busy;
  logic [7:0] released_mask;
  logic [7:0] busy_mask;
  logic [7:0] gate_mask;

  int tx_idle_pct = 12;
  int rx_idle_pct = 84;
  int cycles = 0;
  int sent = 0;
  int settings = 0;
  int fail_count;
  int pending;
  int checked;
  int reused;

  synth_voice_allocator u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .req_type      (req_type),
    .key_number    (key_number),
    .done_voice    (done_voice),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .accepted      (accepted),
    .voice_index   (voice_index),
    .retrigger     (retrigger),
    .was_busy      (was_busy),
    .released_mask (released_mask),
    .busy_mask     (busy_mask),
    .gate_mask     (gate_mask)
  );

  voice_alloc_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .req_type      (req_type),
    .key_number    (key_number),
    .done_voice    (done_voice),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .accepted      (accepted),
    .voice_index   (voice_index),
    .retrigger     (retrigger),
    .was_busy      (was_busy),
    .released_mask (released_mask),
    .busy_mask     (busy_mask),
    .gate_mask     (gate_mask),
    .fail_count    (fail_count),
    .pending       (pending),
    .checked       (checked),
    .reused        (reused)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    out_ready <= ($urandom_range(99) >= rx_idle_pct);
    if (cycles >= CYCLE_LIMIT) begin
      $display("synth_voice_allocator: mismatch");
      $finish;
    end
  end

  task automatic send_req(input logic [1:0] kind, input logic [6:0] key, input logic [2:0] dv);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct && gap < 40) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    req_type   <= kind;
    key_number <= key;
    done_voice <= dv;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic set_config(input logic [1:0] mode, input logic map);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_VOICE_MODE;
    cfg_data  <= mode;
    @(posedge clk);
    cfg_index <= CFG_SAMPLE_MAP;
    cfg_data  <= {1'b0, map};
    @(posedge clk);
    cfg_we <= 1'b0;
    settings++;
  endtask

  initial begin
    int         pick;
    logic [1:0] kind;
    logic [6:0] key;
    logic [2:0] dv;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // note on with no sample map
    send_req(REQ_NOTE_ON, 7'd60, 3'd0);
    drain();
    set_config(MODE_POLY, 1'b1);
    send_req(REQ_NOTE_ON, 7'd0, 3'd7);
    send_req(REQ_NOTE_ON, 7'd127, 3'd0);
    send_req(REQ_NOTE_ON, 7'd85, 3'd0);
    send_req(REQ_NOTE_ON, 7'd42, 3'd0);
    send_req(REQ_NOTE_ON, 7'd1, 3'd0);
    send_req(REQ_NOTE_ON, 7'd2, 3'd0);
    send_req(REQ_NOTE_ON, 7'd4, 3'd0);
    send_req(REQ_NOTE_ON, 7'd8, 3'd0);
    // all held, steal the oldest
    send_req(REQ_NOTE_ON, 7'd100, 3'd0);
    send_req(REQ_NOTE_OFF, 7'd127, 3'd0);
    send_req(REQ_NOTE_OFF, 7'd42, 3'd0);
    send_req(REQ_NOTE_ON, 7'd50, 3'd0);
    // voice done while key held, then note off must skip it
    send_req(REQ_VOICE_DONE, 7'd0, 3'd7);
    send_req(REQ_NOTE_OFF, 7'd8, 3'd0);
    send_req(REQ_NOTE_ON, 7'd9, 3'd0);
    send_req(REQ_VOICE_DONE, 7'd127, 3'd0);
    send_req(REQ_ALL_OFF, 7'd127, 3'd7);
    send_req(REQ_NOTE_OFF, 7'd5, 3'd0);
    drain();
    set_config(MODE_LEGATO, 1'b1);
    send_req(REQ_NOTE_ON, 7'd70, 3'd0);
    send_req(REQ_NOTE_ON, 7'd72, 3'd0);
    send_req(REQ_NOTE_OFF, 7'd72, 3'd0);
    send_req(REQ_NOTE_ON, 7'd74, 3'd0);
    drain();
    set_config(MODE_MONO, 1'b1);
    send_req(REQ_NOTE_ON, 7'd76, 3'd0);
    send_req(REQ_NOTE_ON, 7'd76, 3'd0);
    drain();
    set_config(MODE_SPARE, 1'b1);
    send_req(REQ_NOTE_ON, 7'd90, 3'd0);
    send_req(REQ_ALL_OFF, 7'd0, 3'd0);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      set_config(PHASE_MODE[p], PHASE_MAP[p]);
      case (p / 3)
        0: begin
          tx_idle_pct <= 12;
          rx_idle_pct <= 84;
        end
        1: begin
          tx_idle_pct <= 84;
          rx_idle_pct <= 12;
        end
        default: begin
          tx_idle_pct <= 0;
          rx_idle_pct <= 0;
        end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        pick = $urandom_range(99);
        key  = ($urandom_range(3) == 0) ? 7'($urandom_range(127)) : 7'(60 + $urandom_range(7));
        dv   = 3'($urandom_range(7));
        if (pick < 50) kind = REQ_NOTE_ON;
        else if (pick < 78) kind = REQ_NOTE_OFF;
        else if (pick < 94) kind = REQ_VOICE_DONE;
        else kind = REQ_ALL_OFF;
        send_req(kind, key, dv);
      end
    end

    drain();
    $display("run covered %0d requests over %0d register settings, every voice mode, map on/off",
             sent, settings);
    $display("%0d results compared, %0d note-ons took a voice already in use", checked, reused);
    if (fail_count == 0 && pending == 0) begin
      $display("synth_voice_allocator: match");
    end else begin
      $display("synth_voice_allocator: mismatch");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/sva_pkg.sv
rtl/core/sva_ctrl.sv
rtl/core/sva_datapath.sv
rtl/core/synth_voice_allocator.sv
bench/voice_alloc_checker.sv
bench/tb_top.sv
